// ===== sv/aip_pkg.sv =====
// Shared types and constants of the ASCII decimal integer parser.
`timescale 1ns / 1ps
package aip_pkg;

    localparam int VALUE_W = 64;
    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 5;

    // configuration register indexes
    localparam logic REG_WIDTH_MODE  = 1'b0;
    localparam logic REG_SIGNED_MODE = 1'b1;

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;

    // token length limits, sign included, per width mode 8/16/32/64
    localparam logic [COUNT_W-1:0] LIMIT_SIGNED   [4] = '{5'd4, 5'd6, 5'd11, 5'd21};
    localparam logic [COUNT_W-1:0] LIMIT_UNSIGNED [4] = '{5'd3, 5'd5, 5'd10, 5'd20};

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_TOO_LONG  = 2'd2,
        ST_SIGN_ONLY = 2'd3
    } status_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              stream_end;
    } item_t;

    typedef struct packed {
        logic [1:0] width_mode;
        logic       signed_mode;
    } cfg_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        status_t            status;
        logic [CHAR_W-1:0]  stop_char;
    } result_t;

endpackage

// ===== sv/aip_in_reg.sv =====
// Input register of the parser: holds one accepted item until the core takes it.
`timescale 1ns / 1ps
module aip_in_reg
    import aip_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  advance,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== sv/aip_core.sv =====
// Token state and single-pass next-state and result logic of the parser.
`timescale 1ns / 1ps
module aip_core
    import aip_pkg::*;
#(
    parameter int MAX_WIDTH = 64
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    item_valid,
    input  item_t   item,
    input  logic    out_free,
    output logic    advance,
    output logic    emit,
    output result_t result
);

    localparam logic [6:0]         MAXW    = 7'(MAX_WIDTH);
    localparam logic [COUNT_W-1:0] CNT_MAX = '1;

    logic                 in_token_reg,    in_token_next;
    logic [COUNT_W-1:0]   char_count_reg,  char_count_next;
    logic                 is_negative_reg, is_negative_next;
    logic [MAX_WIDTH-1:0] acc_reg,         acc_next;
    logic                 seen_digit_reg,  seen_digit_next;

    logic                 is_space;
    logic                 is_digit;
    logic                 is_sign;
    logic [MAX_WIDTH-1:0] acc_x10;
    logic [MAX_WIDTH-1:0] signed_acc;
    logic [6:0]           w_full;
    logic [6:0]           w;
    logic [VALUE_W-1:0]   mask;
    logic [VALUE_W-1:0]   top_bit;
    logic [VALUE_W-1:0]   wrapped;
    logic [COUNT_W-1:0]   limit;
    logic [CHAR_W-1:0]    stop;

    always_comb
    begin
        is_space = (item.ch == CH_SPACE) || (item.ch inside {[CH_TAB:CH_CR]});
        is_digit = item.ch inside {[CH_ZERO:CH_NINE]};
        is_sign  = ((item.ch == CH_PLUS) || (item.ch == CH_MINUS)) && (char_count_reg == '0);
        acc_x10  = {acc_reg[MAX_WIDTH-4:0], 3'b000} + {acc_reg[MAX_WIDTH-2:0], 1'b0}
                 + MAX_WIDTH'(item.ch[3:0]);
    end

    // token state update and end-of-token detection
    always_comb
    begin
        in_token_next    = in_token_reg;
        char_count_next  = char_count_reg;
        is_negative_next = is_negative_reg;
        acc_next         = acc_reg;
        seen_digit_next  = seen_digit_reg;
        emit             = 1'b0;
        stop             = '0;
        if (item.stream_end)
        begin
            emit = 1'b1;
        end
        else if (is_space && !in_token_reg)
        begin
            emit = 1'b0;
        end
        else if (is_digit || is_sign)
        begin
            if (is_digit)
            begin
                acc_next        = acc_x10;
                seen_digit_next = 1'b1;
            end
            else
            begin
                is_negative_next = (item.ch == CH_MINUS);
            end
            in_token_next   = 1'b1;
            char_count_next = (char_count_reg == CNT_MAX) ? CNT_MAX : char_count_reg + 1'b1;
        end
        else
        begin
            emit = 1'b1;
            stop = item.ch;
        end
        if (emit)
        begin
            in_token_next    = 1'b0;
            char_count_next  = '0;
            is_negative_next = 1'b0;
            acc_next         = '0;
            seen_digit_next  = 1'b0;
        end
    end

    // result of the token that ends with this item
    always_comb
    begin
        w_full     = 7'd8 << cfg.width_mode;
        w          = (w_full > MAXW) ? MAXW : w_full;
        mask       = {VALUE_W{1'b1}} >> (7'(VALUE_W) - w);
        top_bit    = mask ^ (mask >> 1);
        limit      = cfg.signed_mode ? LIMIT_SIGNED[cfg.width_mode]
                                     : LIMIT_UNSIGNED[cfg.width_mode];
        signed_acc = is_negative_reg ? ('0 - acc_reg) : acc_reg;
        wrapped    = VALUE_W'(signed_acc) & mask;
        result.stop_char = stop;
        if (char_count_reg == '0)
        begin
            result.value  = '0;
            result.status = ST_EMPTY;
        end
        else if (char_count_reg > limit)
        begin
            result.value  = cfg.signed_mode ? {VALUE_W{1'b1}} : mask;
            result.status = ST_TOO_LONG;
        end
        else if (!seen_digit_reg)
        begin
            result.value  = '0;
            result.status = ST_SIGN_ONLY;
        end
        else
        begin
            result.value  = (cfg.signed_mode && |(wrapped & top_bit)) ? (wrapped | ~mask)
                                                                       : wrapped;
            result.status = ST_OK;
        end
    end

    assign advance = item_valid && (!emit || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_token_reg    <= 1'b0;
            char_count_reg  <= '0;
            is_negative_reg <= 1'b0;
            acc_reg         <= '0;
            seen_digit_reg  <= 1'b0;
        end
        else if (advance)
        begin
            in_token_reg    <= in_token_next;
            char_count_reg  <= char_count_next;
            is_negative_reg <= is_negative_next;
            acc_reg         <= acc_next;
            seen_digit_reg  <= seen_digit_next;
        end
    end

endmodule

// ===== sv/aip_out_reg.sv =====
// Result register of the parser: holds one result item until the sink takes it.
`timescale 1ns / 1ps
module aip_out_reg
    import aip_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result_in,
    output logic    out_free,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t result_out
);

    logic    valid_reg;
    result_t result_reg;

    assign out_free   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign result_out = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

endmodule

// ===== sv/ascii_decimal_integer_parser_unit.sv =====
// Top level of the ASCII decimal integer parser.
//
//  channel  | direction | payload                                    | handshake
//  ---------+-----------+--------------------------------------------+--------------------
//  s_*      | in        | tdata: ch; tuser: stream_end               | tvalid / tready
//  m_*      | out       | tdata: value, stop_char; tuser: status     | tvalid / tready
//  cfg_*    | in        | cfg_wdata to register cfg_addr             | cfg_we, no wait
//
// One item per cycle sustained: an item waits in the input register while the token logic
// (multiply by ten and add, or the end-of-token result) runs, and a token's result is
// then registered in the output register, which drives m_*.
// Reset clears the token state and valid flags and loads width_mode = 32 bits, signed.
// A stalled m_* side blocks only items that end a token; digits, signs and skipped
// whitespace keep flowing while a result waits in the output register.
`timescale 1ns / 1ps
module ascii_decimal_integer_parser_unit
    import aip_pkg::*;
#(
    parameter int MAX_WIDTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic [0:0]  s_tuser,   // [0] stream_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] value, [71:64] stop_char
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [1:0]  cfg_wdata
);

    cfg_t    cfg_reg;
    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    logic    emit;
    logic    out_free;
    result_t result;
    result_t result_out;

    // register writes: take effect for the token that ends after them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width_mode  <= 2'd2;
            cfg_reg.signed_mode <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_WIDTH_MODE:  cfg_reg.width_mode  <= cfg_wdata;
                REG_SIGNED_MODE: cfg_reg.signed_mode <= cfg_wdata[0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    assign in_item.ch         = s_tdata;
    assign in_item.stream_end = s_tuser[0];

    // hold the incoming item while the token logic works on it
    aip_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // advance the token state; stall only when a result has nowhere to go
    aip_core #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .advance    (advance),
        .emit       (emit),
        .result     (result)
    );

    aip_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && emit),
        .result_in  (result),
        .out_free   (out_free),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .result_out (result_out)
    );

    assign m_tdata = {result_out.stop_char, result_out.value};
    assign m_tuser = result_out.status;

endmodule

// ===== sv/aip_checker.sv =====
// Port-level assertions of the parser, bound to its top level.
`timescale 1ns / 1ps
module aip_checker
    import aip_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        cfg_we,
    input logic        cfg_addr,
    input logic [1:0]  cfg_wdata
);

    // a result waiting on the sink holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // empty and sign-only tokens give a zero value
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_EMPTY || m_tuser == ST_SIGN_ONLY) |-> m_tdata[63:0] == '0)
        else $error("empty or sign-only result with nonzero value");

    // a digit never ends a token
    a_stop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[71:64] >= CH_ZERO && m_tdata[71:64] <= CH_NINE))
        else $error("digit reported as stop character");

    // a new result needs an earlier accepted item or a stalled input
    a_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2) || $past(s_tvalid && s_tready, 3)
                            || $past(m_tvalid, 1) || !$past(s_tready, 1))
        else $error("result without a source item");

endmodule

bind ascii_decimal_integer_parser_unit aip_checker u_aip_checker (.*);
